// ===== rtl/core/assert_macros.svh =====
// Assertion macros included by positional_list_engine_unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/ple_pkg.sv =====
// Shared widths and operation and status codes of the positional list engine.
package ple_pkg;

  localparam int FUNC_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 5;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef enum logic [FUNC_W-1:0] {
    FN_ADD_FRONT = 3'd0,
    FN_ADD_BACK  = 3'd1,
    FN_ADD_POS   = 3'd2,
    FN_DEL_FRONT = 3'd3,
    FN_DEL_BACK  = 3'd4,
    FN_DEL_POS   = 3'd5,
    FN_READ_ALL  = 3'd6
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

endpackage

// ===== rtl/core/ple_in_if.sv =====
// Request channel of the positional list engine: one operation per transaction.
interface ple_in_if;
  logic                                valid;
  logic                                ready;
  logic [ple_pkg::FUNC_W-1:0]          func;
  logic signed [ple_pkg::VALUE_W-1:0]  value;
  logic [ple_pkg::POS_W-1:0]           position;

  modport source (output valid, output func, output value, output position, input ready);
  modport sink (input valid, input func, input value, input position, output ready);
endinterface

// ===== rtl/core/ple_out_if.sv =====
// Response channel of the positional list engine: one result per transaction.
interface ple_out_if;
  logic                                valid;
  logic                                ready;
  logic [ple_pkg::STATUS_W-1:0]        status;
  logic [ple_pkg::COUNT_W-1:0]         count;
  logic signed [ple_pkg::VALUE_W-1:0]  element;
  logic                                last;

  modport source (output valid, output status, output count, output element, output last,
                  input ready);
  modport sink (input valid, input status, input count, input element, input last,
                output ready);
endinterface

// ===== rtl/core/positional_list_engine_unit.sv =====
// An update shifts elements by read (S_INS, S_DEL) and write (S_INS_WR, S_DEL_WR) steps, then
// waits in S_OUT for its result to go; a read-out reads (S_RA_RD) and offers (S_RA_OUT) each
// element; an empty read-out or a refused update goes straight to S_OUT. One operation at a
// time, the next taken the cycle after the final result; one element moves per read/write pair.
// Reset (rst, synchronous, active high) empties the list and idles the sequencer;
// the entry memory is not cleared, since only entries below the count are ever read.
`include "assert_macros.svh"

module positional_list_engine_unit #(
  parameter int CAPACITY = 16
) (
  input  logic clk,
  input  logic rst,
  ple_in_if.sink    req,
  ple_out_if.source rsp
);
  import ple_pkg::*;

  localparam int LEN_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS_WR,
    S_DEL,
    S_DEL_WR,
    S_RA_RD,
    S_RA_OUT,
    S_OUT
  } state_t;

  state_t                state;
  logic [LEN_W-1:0]      length;
  logic [LEN_W-1:0]      cur;
  logic [LEN_W-1:0]      tgt;
  logic [VALUE_W-1:0]    val;
  status_t               status;

  // Entry memory: one write and one registered read per cycle.
  logic [VALUE_W-1:0]    mem [CAPACITY];
  logic [VALUE_W-1:0]    rdata;
  logic                  mem_we;
  logic                  mem_re;
  logic [IDX_W-1:0]      mem_waddr;
  logic [IDX_W-1:0]      mem_raddr;
  logic [VALUE_W-1:0]    mem_wdata;

  // Decode of the incoming operation.
  logic [CMP_W-1:0]      pos_c;
  logic [CMP_W-1:0]      len_c;
  logic                  full;
  status_t               dec_status;
  state_t                dec_next;
  logic [LEN_W-1:0]      dec_cur;
  logic [LEN_W-1:0]      dec_tgt;

  logic [LEN_W:0]        cur_inc;
  logic [LEN_W:0]        len_ext;
  logic                  ra_last;

  assign pos_c   = CMP_W'(req.position);
  assign len_c   = CMP_W'(length);
  assign full    = (length == LEN_W'(CAPACITY));
  assign cur_inc = {1'b0, cur} + 1'b1;
  assign len_ext = {1'b0, length};
  assign ra_last = (cur_inc == len_ext);

  always_comb begin
    dec_status = ST_OK;
    dec_next   = S_OUT;
    dec_cur    = '0;
    dec_tgt    = '0;
    case (func_t'(req.func))
      FN_ADD_FRONT: begin
        if (full) begin
          dec_status = ST_FULL;
        end else begin
          dec_next = S_INS;
          dec_cur  = length;
          dec_tgt  = '0;
        end
      end
      FN_ADD_BACK: begin
        if (full) begin
          dec_status = ST_FULL;
        end else begin
          dec_next = S_INS;
          dec_cur  = length;
          dec_tgt  = length;
        end
      end
      FN_ADD_POS: begin
        if (length == '0 && pos_c != CMP_W'(1)) begin
          dec_status = ST_EMPTY;
        end else if (pos_c == '0 || pos_c > len_c + CMP_W'(1)) begin
          dec_status = ST_BADPOS;
        end else if (full) begin
          dec_status = ST_FULL;
        end else begin
          dec_next = S_INS;
          dec_cur  = length;
          dec_tgt  = LEN_W'(pos_c - CMP_W'(1));
        end
      end
      FN_DEL_FRONT: begin
        if (length == '0) begin
          dec_status = ST_EMPTY;
        end else begin
          dec_next = S_DEL;
          dec_cur  = '0;
        end
      end
      FN_DEL_BACK: begin
        if (length == '0) begin
          dec_status = ST_EMPTY;
        end else begin
          dec_next = S_DEL;
          dec_cur  = length - 1'b1;
        end
      end
      FN_DEL_POS: begin
        if (length == '0) begin
          dec_status = ST_EMPTY;
        end else if (pos_c == '0 || pos_c > len_c) begin
          dec_status = ST_BADPOS;
        end else begin
          dec_next = S_DEL;
          dec_cur  = LEN_W'(pos_c - CMP_W'(1));
        end
      end
      FN_READ_ALL: begin
        if (length == '0) begin
          dec_status = ST_EMPTY;
        end else begin
          dec_next = S_RA_RD;
          dec_cur  = '0;
        end
      end
      default: begin
        dec_status = ST_OK;
      end
    endcase
  end

  // Memory port control: each shift step reads one neighbor, then writes it one place over.
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = cur[IDX_W-1:0];
    mem_raddr = cur[IDX_W-1:0];
    mem_wdata = rdata;
    case (state)
      S_INS: begin
        if (cur > tgt) begin
          mem_re    = 1'b1;
          mem_raddr = IDX_W'(cur - 1'b1);
        end else begin
          mem_we    = 1'b1;
          mem_waddr = tgt[IDX_W-1:0];
          mem_wdata = val;
        end
      end
      S_INS_WR: begin
        mem_we = 1'b1;
      end
      S_DEL: begin
        if (cur_inc < len_ext) begin
          mem_re    = 1'b1;
          mem_raddr = cur_inc[IDX_W-1:0];
        end
      end
      S_DEL_WR: begin
        mem_we = 1'b1;
      end
      S_RA_RD: begin
        mem_re = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      length <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            val    <= req.value;
            status <= dec_status;
            cur    <= dec_cur;
            tgt    <= dec_tgt;
            state  <= dec_next;
          end
        end
        S_INS: begin
          if (cur > tgt) begin
            state <= S_INS_WR;
          end else begin
            length <= length + 1'b1;
            status <= ST_OK;
            state  <= S_OUT;
          end
        end
        S_INS_WR: begin
          cur   <= cur - 1'b1;
          state <= S_INS;
        end
        S_DEL: begin
          if (cur_inc < len_ext) begin
            state <= S_DEL_WR;
          end else begin
            length <= length - 1'b1;
            status <= ST_OK;
            state  <= S_OUT;
          end
        end
        S_DEL_WR: begin
          cur   <= cur_inc[LEN_W-1:0];
          state <= S_DEL;
        end
        S_RA_RD: begin
          state <= S_RA_OUT;
        end
        S_RA_OUT: begin
          if (rsp.ready) begin
            if (ra_last) begin
              state <= S_IDLE;
            end else begin
              cur   <= cur_inc[LEN_W-1:0];
              state <= S_RA_RD;
            end
          end
        end
        S_OUT: begin
          if (rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready   = (state == S_IDLE) && !rst;
  assign rsp.valid   = (state == S_OUT) || (state == S_RA_OUT);
  assign rsp.status  = (state == S_RA_OUT) ? ST_OK : status;
  assign rsp.count   = COUNT_W'(length);
  assign rsp.element = (state == S_RA_OUT) ? rdata : '0;
  assign rsp.last    = (state == S_OUT) ? 1'b1 : ra_last;

  `ASSERT_ALWAYS(a_len_bound, clk, rst, length <= LEN_W'(CAPACITY), "count above capacity")
  `ASSERT_SAME(a_no_overlap, clk, rst, req.ready, !rsp.valid, "request taken while result pending")
  `ASSERT_NEXT(a_last_idle, clk, rst, rsp.valid && rsp.ready && rsp.last, state == S_IDLE, "sequencer busy after final result")
  `ASSERT_SAME(a_len_step, clk, rst, !$stable(length), length == LEN_W'($past(length) + 1'b1) || $past(length) == LEN_W'(length + 1'b1), "count moved by more than one")
  `ASSERT_SAME(a_elem_zero, clk, rst, rsp.valid && rsp.status != ST_OK, rsp.element == '0, "element not zero on a failed operation")

endmodule

// ===== bench/tb_positional_list_engine_unit.sv =====
`timescale 1ns / 1ps
// Self-checking bench for positional_list_engine_unit: directed and random list operations.
module tb_positional_list_engine_unit;
  import ple_pkg::*;

  localparam int CAPACITY = 16;
  localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;
  localparam int RANDOM_OPS = 85;
  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL_CYCLES = 80;

  typedef struct packed {
    logic [FUNC_W-1:0]         fn;
    logic signed [VALUE_W-1:0] val;
    logic [POS_W-1:0]          pos;
  } list_op_t;

  typedef struct packed {
    status_t                   status;
    logic [COUNT_W-1:0]        count;
    logic signed [VALUE_W-1:0] element;
    logic                      last;
  } list_result_t;

  logic clk;
  logic rst = 1'b1;

  ple_in_if  req_if ();
  ple_out_if rsp_if ();

  positional_list_engine_unit #(.CAPACITY(CAPACITY)) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  // Contents of the list as the design should hold them after every accepted operation.
  logic signed [VALUE_W-1:0] model_list[$];
  list_result_t              due_results[$];
  list_op_t                  pending_ops[$];

  int mismatches = 0;
  int ops_accepted = 0;
  int results_checked = 0;
  int directed_ops = 0;
  int send_gap = 0;
  int stall_left = 0;
  int idle_cycles = 0;
  int calm_left = 0;
  bit calm = 1'b0;
  bit watchdog_fired = 1'b0;
  list_op_t     next_op;
  list_result_t due;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [VALUE_W-1:0] got, logic [VALUE_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h (result %0d)",
                                name, got, want, results_checked));
    end
  endtask

  // Applies one operation to the list copy and queues the results it must produce.
  function automatic void predict_list_op(list_op_t op);
    status_t      st;
    list_result_t r;
    int           n;
    int           p;
    st = ST_OK;
    n = model_list.size();
    p = int'(op.pos);
    case (op.fn)
      FN_ADD_FRONT: begin
        if (n >= CAPACITY) st = ST_FULL;
        else model_list.push_front(op.val);
      end
      FN_ADD_BACK: begin
        if (n >= CAPACITY) st = ST_FULL;
        else model_list.push_back(op.val);
      end
      FN_ADD_POS: begin
        // Position is judged before fullness.
        if (n == 0 && p != 1) st = ST_EMPTY;
        else if (p < 1 || p > n + 1) st = ST_BADPOS;
        else if (n >= CAPACITY) st = ST_FULL;
        else model_list.insert(p - 1, op.val);
      end
      FN_DEL_FRONT: begin
        if (n == 0) st = ST_EMPTY;
        else void'(model_list.pop_front());
      end
      FN_DEL_BACK: begin
        if (n == 0) st = ST_EMPTY;
        else void'(model_list.pop_back());
      end
      FN_DEL_POS: begin
        if (n == 0) st = ST_EMPTY;
        else if (p < 1 || p > n) st = ST_BADPOS;
        else model_list.delete(p - 1);
      end
      FN_READ_ALL: begin
        if (n == 0) begin
          st = ST_EMPTY;
        end else begin
          foreach (model_list[i]) begin
            r.status  = ST_OK;
            r.count   = COUNT_W'(n);
            r.element = model_list[i];
            r.last    = (i == n - 1);
            due_results.push_back(r);
          end
          return;
        end
      end
      default: ;
    endcase
    r.status  = st;
    r.count   = COUNT_W'(model_list.size());
    r.element = '0;
    r.last    = 1'b1;
    due_results.push_back(r);
  endfunction

  function automatic int pick_gap();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic logic signed [VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0: return {1'b1, {(VALUE_W-1){1'b0}}};
      1: return {1'b0, {(VALUE_W-1){1'b1}}};
      2: return '1;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] bad_pos(int lo);
    if ($urandom_range(0, 3) == 0) return '0;
    return POS_W'($urandom_range(lo, 31));
  endfunction

  function automatic void queue_op(logic [FUNC_W-1:0] fn, logic signed [VALUE_W-1:0] val,
                                   logic [POS_W-1:0] pos);
    list_op_t op;
    op.fn  = fn;
    op.val = val;
    op.pos = pos;
    pending_ops.push_back(op);
  endfunction

  // The generator tracks only the length, which is all it needs to keep sequences legal.
  function automatic void queue_grow(inout int len);
    case ($urandom_range(0, 2))
      0: queue_op(FN_ADD_FRONT, rand_value(), POS_W'($urandom));
      1: queue_op(FN_ADD_BACK, rand_value(), POS_W'($urandom));
      default: queue_op(FN_ADD_POS, rand_value(), POS_W'($urandom_range(1, len + 1)));
    endcase
    len++;
  endfunction

  function automatic void queue_shrink(inout int len);
    case ($urandom_range(0, 2))
      0: queue_op(FN_DEL_FRONT, rand_value(), POS_W'($urandom));
      1: queue_op(FN_DEL_BACK, rand_value(), POS_W'($urandom));
      default: queue_op(FN_DEL_POS, rand_value(), POS_W'($urandom_range(1, len)));
    endcase
    len--;
  endfunction

  // Operations that leave the length alone: refusals, read-outs and the unused code.
  function automatic void queue_noise(int len);
    case ($urandom_range(0, 4))
      0: queue_op(FN_READ_ALL, rand_value(), POS_W'($urandom));
      1: queue_op(FN_ADD_POS, rand_value(), bad_pos(len + 2));
      2: queue_op(FN_DEL_POS, rand_value(), bad_pos(len + 1));
      3: begin
        if (len == 0) queue_op(FN_DEL_FRONT, rand_value(), POS_W'($urandom));
        else queue_op(FN_READ_ALL, rand_value(), POS_W'($urandom));
      end
      default: queue_op(FN_UNUSED, rand_value(), POS_W'($urandom));
    endcase
  endfunction

  function automatic void queue_overflow();
    queue_op(FN_ADD_FRONT, rand_value(), POS_W'($urandom));
    queue_op(FN_ADD_BACK, rand_value(), POS_W'($urandom));
    queue_op(FN_ADD_POS, rand_value(), POS_W'($urandom_range(1, CAPACITY + 1)));
    queue_op(FN_ADD_POS, rand_value(), bad_pos(CAPACITY + 2));
  endfunction

  always @(posedge clk) begin
    if (calm_left > 0) begin
      calm_left <= calm_left - 1;
    end else begin
      calm      <= ($urandom_range(0, 3) == 0);
      calm_left <= $urandom_range(20, 120);
    end
  end

  // Request driver: the operation on the bus is predicted at the edge that accepts it.
  always @(posedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        predict_list_op('{fn: req_if.func, val: req_if.value, pos: req_if.position});
        ops_accepted++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (send_gap > 0) begin
          send_gap     <= send_gap - 1;
          req_if.valid <= 1'b0;
        end else if (pending_ops.size() != 0) begin
          next_op          = pending_ops.pop_front();
          req_if.func     <= next_op.fn;
          req_if.value    <= next_op.val;
          req_if.position <= next_op.pos;
          req_if.valid    <= 1'b1;
          send_gap        <= pick_gap();
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor with random back pressure.
  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: status %0d count %0d",
                                    rsp_if.status, rsp_if.count));
        end else begin
          due = due_results.pop_front();
          check_field("status", VALUE_W'(rsp_if.status), VALUE_W'(due.status));
          check_field("count", VALUE_W'(rsp_if.count), VALUE_W'(due.count));
          check_field("element", rsp_if.element, due.element);
          check_field("last", VALUE_W'(rsp_if.last), VALUE_W'(due.last));
        end
        results_checked++;
      end
      if (stall_left > 0) begin
        stall_left   <= stall_left - 1;
        rsp_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        stall_left   <= pick_gap();
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      watchdog_fired <= 1'b1;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int gen_len;
    int goal;
    int low_mark;
    int tail;
    bit first_round;
    req_if.valid    = 1'b0;
    req_if.func     = '0;
    req_if.value    = '0;
    req_if.position = '0;
    rsp_if.ready    = 1'b0;

    // Refusals on the empty list, then a short list built and taken apart.
    queue_op(FN_READ_ALL, '0, '0);
    queue_op(FN_DEL_FRONT, '0, '0);
    queue_op(FN_DEL_BACK, '0, '0);
    queue_op(FN_DEL_POS, '0, 5'd1);
    queue_op(FN_ADD_POS, 32'sd7, 5'd2);
    queue_op(FN_ADD_POS, 32'sd7, 5'd0);
    queue_op(FN_ADD_POS, {1'b1, {(VALUE_W-1){1'b0}}}, 5'd1);
    queue_op(FN_ADD_FRONT, {1'b0, {(VALUE_W-1){1'b1}}}, 5'd31);
    queue_op(FN_ADD_BACK, -32'sd1, 5'd0);
    queue_op(FN_ADD_POS, 32'sd9, 5'd0);
    queue_op(FN_ADD_POS, 32'sd9, 5'd5);
    queue_op(FN_ADD_POS, '0, 5'd4);
    queue_op(FN_ADD_POS, 32'sh5555_5555, 5'd2);
    queue_op(FN_DEL_POS, '0, 5'd0);
    queue_op(FN_DEL_POS, '0, 5'd31);
    queue_op(FN_DEL_POS, '0, 5'd6);
    queue_op(FN_READ_ALL, '1, 5'd16);
    queue_op(FN_UNUSED, 32'sh2aaa_aaaa, 5'd10);
    queue_op(FN_DEL_POS, '0, 5'd3);
    queue_op(FN_DEL_POS, '0, 5'd4);
    queue_op(FN_DEL_FRONT, '0, '0);
    queue_op(FN_DEL_BACK, '0, '0);
    queue_op(FN_READ_ALL, '0, '0);
    queue_op(FN_DEL_POS, '0, 5'd1);
    queue_op(FN_READ_ALL, '0, '0);
    directed_ops = pending_ops.size();

    // Rounds of fill and drain; the first round always reaches a full list.
    gen_len = 0;
    first_round = 1'b1;
    while (pending_ops.size() < directed_ops + RANDOM_OPS) begin
      goal = (first_round || $urandom_range(0, 2) != 0) ? CAPACITY
                                                         : $urandom_range(1, CAPACITY - 1);
      first_round = 1'b0;
      while (gen_len < goal) begin
        case ($urandom_range(0, 9))
          7, 8: queue_noise(gen_len);
          9: begin
            if (gen_len > 0) queue_shrink(gen_len);
            else queue_noise(gen_len);
          end
          default: queue_grow(gen_len);
        endcase
      end
      if (gen_len == CAPACITY) queue_overflow();
      queue_op(FN_READ_ALL, rand_value(), POS_W'($urandom));
      low_mark = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, gen_len - 1);
      while (gen_len > low_mark) begin
        case ($urandom_range(0, 9))
          7, 8: queue_noise(gen_len);
          9: begin
            if (gen_len < CAPACITY) queue_grow(gen_len);
            else queue_shrink(gen_len);
          end
          default: queue_shrink(gen_len);
        endcase
      end
      if (gen_len == 0) begin
        queue_noise(gen_len);
        queue_noise(gen_len);
      end
    end
    // The last round overshoots; every operation is legal, so the tail is simply dropped.
    while (pending_ops.size() > directed_ops + RANDOM_OPS) begin
      void'(pending_ops.pop_back());
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (!watchdog_fired &&
           (pending_ops.size() != 0 || req_if.valid || due_results.size() != 0)) begin
      @(posedge clk);
    end
    tail = 0;
    while (!watchdog_fired && tail < TAIL_CYCLES) begin
      @(posedge clk);
      tail++;
    end

    if (watchdog_fired) begin
      $display("No transaction for %0d cycles; %0d results still expected.",
               IDLE_LIMIT, due_results.size());
      $display("tb_positional_list_engine_unit NOT OK");
    end else begin
      while (due_results.size() != 0) begin
        due = due_results.pop_front();
        report_mismatch($sformatf("expected result never arrived: status %0d count %0d",
                                  due.status, due.count));
      end
      $display("Ran %0d list operations (%0d directed), checked %0d results, %0d mismatches.",
               ops_accepted, directed_ops, results_checked, mismatches);
      $display("Covered empty and full lists, bad positions, read-outs and random stalls.");
      if (mismatches == 0) begin
        $display("tb_positional_list_engine_unit OK");
      end else begin
        $display("tb_positional_list_engine_unit NOT OK");
      end
    end
    $finish;
  end

endmodule
